### rtl/rhd_pkg.sv
`timescale 1ns / 1ps

package rhd_pkg;

    localparam int HIST_DEPTH = 128;
    localparam int HIST_AW    = 7;
    localparam logic [7:0] HIST_RESET = 8'h39;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_READ
    } state_t;

endpackage

### rtl/rle_history_decoder.sv
`timescale 1ns / 1ps

// channel | signals                              | dir | word
// --------+--------------------------------------+-----+---------------------------------
// in      | in_valid, in_ready, in_byte          | in  | one encoded stream byte
// out     | out_valid, out_ready, out_byte,      | out | decoded byte, repeat count,
//         | repeat_res, last                     |     | last-of-item flag
//
// Literal and marker bytes: taken back to back while the output register drains.
// Run count c >= 0: c + 1 history entries are written; the single history write port fills one entry per cycle.
// Back-reference: the history read is registered, and S_READ waits out output stalls.
// Reset: async, active low; history entries read as 0x39 until written (per-entry valid bits).
// Output stalls stop input only when the output register holds an unread word.

module rle_history_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [7:0] repeat_res,
    output logic       last
);
    import rhd_pkg::*;

    logic [7:0]            hist_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] hist_valid_reg;

    state_t state_reg, state_next;

    logic [HIST_AW-1:0] wp_reg, wp_next;
    logic [7:0]         prev_reg, prev_next;
    logic               prev_valid_reg, prev_valid_next;
    logic               count_pending_reg, count_pending_next;
    logic [HIST_AW-1:0] cnt_reg, cnt_next;

    logic [7:0]         rd_data_reg;
    logic               src_valid_reg;
    logic               fwd_reg;
    logic               rd_en;
    logic [HIST_AW-1:0] rd_addr;

    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic [7:0]         repeat_reg;
    logic               last_reg;
    logic               out_free;
    logic               out_load;
    logic [7:0]         out_byte_next;
    logic [7:0]         repeat_next;
    logic               last_next;

    logic               mem_we;
    logic [7:0]         mem_wdata;
    logic               accept;
    logic               is_marker;
    logic [7:0]         back_val;

    assign out_free  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign is_marker = !count_pending_reg && prev_valid_reg && (in_byte == prev_reg);
    assign rd_addr   = wp_reg + HIST_AW'(1) + in_byte[HIST_AW-1:0];
    assign back_val  = fwd_reg ? prev_reg : (src_valid_reg ? rd_data_reg : HIST_RESET);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && count_pending_reg)
                begin
                    if (in_byte[7])
                        state_next = S_READ;
                    else if (in_byte[HIST_AW-1:0] != '0)
                        state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (cnt_reg == HIST_AW'(1))
                    state_next = S_IDLE;
            end
            S_READ:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        in_ready           = 1'b0;
        mem_we             = 1'b0;
        mem_wdata          = prev_reg;
        rd_en              = 1'b0;
        out_load           = 1'b0;
        out_byte_next      = prev_reg;
        repeat_next        = 8'd1;
        last_next          = 1'b1;
        wp_next            = wp_reg;
        prev_next          = prev_reg;
        prev_valid_next    = prev_valid_reg;
        count_pending_next = count_pending_reg;
        cnt_next           = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = out_free;
                if (accept)
                begin
                    if (count_pending_reg)
                    begin
                        count_pending_next = 1'b0;
                        prev_valid_next    = 1'b0;
                        mem_we             = 1'b1;
                        wp_next            = wp_reg + HIST_AW'(1);
                        out_load           = 1'b1;
                        if (in_byte[7])
                        begin
                            rd_en     = 1'b1;
                            last_next = 1'b0;
                        end
                        else
                        begin
                            repeat_next = in_byte + 8'd1;
                            cnt_next    = in_byte[HIST_AW-1:0];
                        end
                    end
                    else if (is_marker)
                    begin
                        count_pending_next = 1'b1;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        mem_wdata       = in_byte;
                        wp_next         = wp_reg + HIST_AW'(1);
                        prev_next       = in_byte;
                        prev_valid_next = 1'b1;
                        out_load        = 1'b1;
                        out_byte_next   = in_byte;
                    end
                end
            end
            S_FILL:
            begin
                mem_we   = 1'b1;
                wp_next  = wp_reg + HIST_AW'(1);
                cnt_next = cnt_reg - HIST_AW'(1);
            end
            S_READ:
            begin
                if (out_free)
                begin
                    mem_we        = 1'b1;
                    mem_wdata     = back_val;
                    wp_next       = wp_reg + HIST_AW'(1);
                    out_load      = 1'b1;
                    out_byte_next = back_val;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            wp_reg            <= '0;
            prev_reg          <= '0;
            prev_valid_reg    <= 1'b0;
            count_pending_reg <= 1'b0;
            cnt_reg           <= '0;
            hist_valid_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            wp_reg            <= wp_next;
            prev_reg          <= prev_next;
            prev_valid_reg    <= prev_valid_next;
            count_pending_reg <= count_pending_next;
            cnt_reg           <= cnt_next;
            if (mem_we)
                hist_valid_reg[wp_reg] <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[wp_reg] <= mem_wdata;
        if (rd_en)
        begin
            rd_data_reg   <= hist_mem[rd_addr];
            src_valid_reg <= hist_valid_reg[rd_addr];
            fwd_reg       <= (rd_addr == wp_reg);
        end
        if (out_load)
        begin
            out_byte_reg <= out_byte_next;
            repeat_reg   <= repeat_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign repeat_res = repeat_reg;
    assign last       = last_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output register overwritten");

    a_pending_prev: assert property (@(posedge clk) disable iff (!rst_n)
        count_pending_reg |-> prev_valid_reg)
        else $error("count pending without previous byte");

    a_fill_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (cnt_reg != '0))
        else $error("fill with zero count");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input taken while busy");

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && out_load) |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("back-reference result lost");

endmodule
